>>> hdl/sgsg_pkg.sv
// Shared types, codes and constants of the scaled glyph span generator.
package sgsg_pkg;

   // Default values of the top-level parameters
   localparam int FONT_CODES_DEF = 256;
   localparam int MAX_SCALE_DEF  = 4;
   localparam int ADDR_BITS_DEF  = 24;

   // Depth of the queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;

   // Fixed field widths
   localparam int CODE_BITS   = 8;
   localparam int WORD_BITS   = 64;
   localparam int ROW_BITS    = 8;
   localparam int POS_BITS    = 12;
   localparam int COLOR_BITS  = 32;
   localparam int SCALE_BITS  = 3;
   localparam int STRIDE_BITS = 13;
   localparam int LINE_BITS   = 24;
   localparam int GLYPH_ROWS  = 16;
   // pos_y * stride + pos_x always fits in this many bits
   localparam int BASE_BITS   = 25;

   // Action codes of an input transaction
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_DRAW = 1'b1;

   // Configuration register indexes
   localparam logic CSR_SCREEN_WIDTH = 1'b0;
   localparam logic CSR_MAX_CODE     = 1'b1;

   // Configuration reset values
   localparam logic [STRIDE_BITS-1:0] SCREEN_WIDTH_RST = 13'd1024;
   localparam logic [CODE_BITS-1:0]   MAX_CODE_RST     = 8'd127;

   // Classified command handed from front to back
   typedef struct packed {
      logic                  is_load;
      logic                  black;
      logic [CODE_BITS-1:0]  code;
      logic                  half;
      logic [WORD_BITS-1:0]  word;
      logic [COLOR_BITS-1:0] color;
      logic [SCALE_BITS-1:0] scale;
   } cmd_type;

   // Back part sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RD_LO,
      BK_RD_HI,
      BK_SPAN
   } back_state_type;

endpackage

>>> hdl/sgsg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sgsg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/sgsg_queue.sv
// Small register queue between the front and back parts.
module sgsg_queue #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff,  count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CntW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/sgsg_front.sv
// Front part: classifies input transactions and works out the cell base offset.
module sgsg_front
   import sgsg_pkg::*;
#(
   parameter int FONT_CODES = FONT_CODES_DEF,
   parameter int MAX_SCALE  = MAX_SCALE_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                   req_valid,
   input  logic                   req_action,
   input  logic [CODE_BITS-1:0]   req_char_code,
   input  logic                   req_word_half,
   input  logic [WORD_BITS-1:0]   req_font_word,
   input  logic [POS_BITS-1:0]    req_pos_x,
   input  logic [POS_BITS-1:0]    req_pos_y,
   input  logic [COLOR_BITS-1:0]  req_fg_color,
   input  logic [SCALE_BITS-1:0]  req_scale,
   input  logic                   queue_full,
   input  logic [STRIDE_BITS-1:0] screen_width,
   input  logic [CODE_BITS-1:0]   max_code,
   output logic                   push,
   output cmd_type                cmd,
   output logic [ADDR_BITS-1:0]   base_addr
);

   logic                  out_of_font;
   logic [SCALE_BITS-1:0] scale_sat;
   logic [BASE_BITS-1:0]  base_full;

   assign out_of_font = ({1'b0, req_char_code} >= (CODE_BITS + 1)'(FONT_CODES));

   always_comb begin
      scale_sat = req_scale;
      if (req_scale == '0) begin
         scale_sat = SCALE_BITS'(1);
      end else if (req_scale > SCALE_BITS'(MAX_SCALE)) begin
         scale_sat = SCALE_BITS'(MAX_SCALE);
      end
   end

   assign base_full = BASE_BITS'(req_pos_y) * BASE_BITS'(screen_width)
                      + BASE_BITS'(req_pos_x);
   assign base_addr = ADDR_BITS'(base_full);

   always_comb begin
      cmd.is_load = (req_action == ACT_LOAD);
      cmd.black   = (req_char_code > max_code) || out_of_font;
      cmd.code    = req_char_code;
      cmd.half    = req_word_half;
      cmd.word    = req_font_word;
      cmd.color   = req_fg_color;
      cmd.scale   = scale_sat;
   end

   // drop loads outside the font: they leave no trace
   assign push = req_valid && !queue_full && !(cmd.is_load && out_of_font);

endmodule

>>> hdl/sgsg_back.sv
// Back part: performs font loads and emits one span per screen line of a glyph.
module sgsg_back
   import sgsg_pkg::*;
#(
   parameter int FONT_CODES = FONT_CODES_DEF,
   parameter int MAX_SCALE  = MAX_SCALE_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  cmd_type                q_cmd,
   input  logic [ADDR_BITS-1:0]   q_base,
   output logic                   q_pop,
   input  logic [STRIDE_BITS-1:0] screen_width,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LINE_BITS-1:0]   rsp_line_addr,
   output logic [ROW_BITS-1:0]    rsp_pixel_bits,
   output logic [COLOR_BITS-1:0]  rsp_span_color,
   output logic [SCALE_BITS-1:0]  rsp_span_scale,
   output logic                   rsp_last
);

   localparam int Depth = 2 * FONT_CODES;
   localparam int AddrW = $clog2(Depth);
   localparam int CodeW = $clog2(FONT_CODES);
   localparam int RepW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int RowW  = $clog2(GLYPH_ROWS);

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [RowW-1:0]       row_ff;
   logic [RepW-1:0]       rep_ff;
   logic [WORD_BITS-1:0]  glyph_lo_ff;

   logic                  rsp_valid_ff;
   logic [LINE_BITS-1:0]  rsp_line_addr_ff;
   logic [ROW_BITS-1:0]   rsp_pixel_bits_ff;
   logic [COLOR_BITS-1:0] rsp_span_color_ff;
   logic [SCALE_BITS-1:0] rsp_span_scale_ff;
   logic                  rsp_last_ff;

   logic                  ram_we, ram_re;
   logic [AddrW-1:0]      ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0]  ram_rdata;
   logic                  out_free, span_load, rep_end, span_last;
   logic [WORD_BITS-1:0]  word_sel;
   logic [ROW_BITS-1:0]   span_bits;

   sgsg_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (Depth)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_cmd.word),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rep_end   = (rep_ff == RepW'(cmd_ff.scale - SCALE_BITS'(1)));
   assign span_last = (row_ff == RowW'(GLYPH_ROWS - 1)) && rep_end;

   // rows 8..15 come from the upper word, still held in the RAM read register
   assign word_sel  = row_ff[RowW-1] ? ram_rdata : glyph_lo_ff;
   assign span_bits = cmd_ff.black ? '0 : word_sel[{row_ff[RowW-2:0], 3'b000} +: ROW_BITS];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && !q_cmd.is_load) begin
               state_in = BK_RD_LO;
            end
         end
         BK_RD_LO: state_in = BK_RD_HI;
         BK_RD_HI: state_in = BK_SPAN;
         BK_SPAN: begin
            if (out_free && span_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = {cmd_ff.code[CodeW-1:0], 1'b0};
      span_load = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_pop  = q_valid;
            ram_we = q_valid && q_cmd.is_load;
         end
         BK_RD_LO: begin
            ram_re    = 1'b1;
            ram_raddr = {cmd_ff.code[CodeW-1:0], 1'b0};
         end
         BK_RD_HI: begin
            ram_re    = 1'b1;
            ram_raddr = {cmd_ff.code[CodeW-1:0], 1'b1};
         end
         BK_SPAN: span_load = out_free;
         default: ;
      endcase
   end

   assign ram_waddr = {q_cmd.code[CodeW-1:0], q_cmd.half};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (span_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && q_valid && !q_cmd.is_load) begin
         cmd_ff  <= q_cmd;
         addr_ff <= q_base;
         row_ff  <= '0;
         rep_ff  <= '0;
      end
      if (state_ff == BK_RD_HI) begin
         glyph_lo_ff <= ram_rdata;
      end
      if (span_load) begin
         rsp_line_addr_ff  <= LINE_BITS'(addr_ff);
         rsp_pixel_bits_ff <= span_bits;
         rsp_span_color_ff <= cmd_ff.black ? '0 : cmd_ff.color;
         rsp_span_scale_ff <= cmd_ff.scale;
         rsp_last_ff       <= span_last;
         addr_ff           <= addr_ff + ADDR_BITS'(screen_width);
         if (rep_end) begin
            rep_ff <= '0;
            row_ff <= row_ff + 1'b1;
         end else begin
            rep_ff <= rep_ff + 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_addr  = rsp_line_addr_ff;
   assign rsp_pixel_bits = rsp_pixel_bits_ff;
   assign rsp_span_color = rsp_span_color_ff;
   assign rsp_span_scale = rsp_span_scale_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> hdl/scaled_glyph_span_generator.sv
// Top level of the scaled glyph span generator: 8x16 bitmap font to line spans.
//
// Use: the request channel (req_*) carries one transaction per item. A load
// (action 0) writes one 64-bit font word, eight glyph rows, for a code and a
// half; it gives no response. A draw (action 1) gives 16*scale response
// transactions (rsp_*), one per frame-buffer line from top to bottom, each with
// the line offset, the eight glyph bits, the colour and the scale; rsp_last
// marks the final span. Codes above max_code, or outside the font, draw a
// black cell. Configuration registers (screen_width, max_code) are to be written
// through csr_* only while no work is outstanding; the block does not enforce it.
// A draw is popped from the queue, then the back part reads the two font words of
// its glyph (BK_RD_LO, BK_RD_HI) before its spans start; spans then follow one per
// cycle while rsp_stall is low, through the single span output register. A load is
// written to the font RAM straight from the back part's idle state.
// A two-entry queue parts the front from the back: requests are taken while
// the back still draws, and req_stall rises only when that queue is full.
// When rsp_stall is high the current span holds and the back part waits.
// Reset clears the queue, the sequencer and the response valid, and restores
// screen_width to 1024 and max_code to 127; the font keeps no reset value.
module scaled_glyph_span_generator
   import sgsg_pkg::*;
#(
   parameter int FONT_CODES = FONT_CODES_DEF,
   parameter int MAX_SCALE  = MAX_SCALE_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [CODE_BITS-1:0]   req_char_code,
   input  logic                   req_word_half,
   input  logic [WORD_BITS-1:0]   req_font_word,
   input  logic [POS_BITS-1:0]    req_pos_x,
   input  logic [POS_BITS-1:0]    req_pos_y,
   input  logic [COLOR_BITS-1:0]  req_fg_color,
   input  logic [SCALE_BITS-1:0]  req_scale,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LINE_BITS-1:0]   rsp_line_addr,
   output logic [ROW_BITS-1:0]    rsp_pixel_bits,
   output logic [COLOR_BITS-1:0]  rsp_span_color,
   output logic [SCALE_BITS-1:0]  rsp_span_scale,
   output logic                   rsp_last,
   // configuration write port
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [STRIDE_BITS-1:0] csr_wdata
);

   localparam int EntryW = $bits(cmd_type) + ADDR_BITS;

   logic [STRIDE_BITS-1:0] screen_width_ff;
   logic [CODE_BITS-1:0]   max_code_ff;

   logic                   push, queue_full, q_valid, q_pop;
   cmd_type                front_cmd, q_cmd;
   logic [ADDR_BITS-1:0]   front_base, q_base;
   logic [EntryW-1:0]      q_data;

   // Configuration registers: take a write whenever the enable is high
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= SCREEN_WIDTH_RST;
         max_code_ff     <= MAX_CODE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: screen_width_ff <= csr_wdata;
            CSR_MAX_CODE:     max_code_ff     <= csr_wdata[CODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Front: classify the request and compute the cell's base offset
   sgsg_front #(
      .FONT_CODES (FONT_CODES),
      .MAX_SCALE  (MAX_SCALE),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .req_valid     (req_valid),
      .req_action    (req_action),
      .req_char_code (req_char_code),
      .req_word_half (req_word_half),
      .req_font_word (req_font_word),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_fg_color  (req_fg_color),
      .req_scale     (req_scale),
      .queue_full    (queue_full),
      .screen_width  (screen_width_ff),
      .max_code      (max_code_ff),
      .push          (push),
      .cmd           (front_cmd),
      .base_addr     (front_base)
   );

   // Hold the request back only while the queue has no room
   assign req_stall = queue_full;

   // Queue: loads travel in order with draws so a draw always sees older loads
   sgsg_queue #(
      .WIDTH (EntryW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_cmd, front_base}),
      .full      (queue_full),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .pop       (q_pop)
   );

   assign q_cmd  = q_data[EntryW-1:ADDR_BITS];
   assign q_base = q_data[ADDR_BITS-1:0];

   // Back: write the font, or read a glyph and step down its lines
   sgsg_back #(
      .FONT_CODES (FONT_CODES),
      .MAX_SCALE  (MAX_SCALE),
      .ADDR_BITS  (ADDR_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_base         (q_base),
      .q_pop          (q_pop),
      .screen_width   (screen_width_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_addr  (rsp_line_addr),
      .rsp_pixel_bits (rsp_pixel_bits),
      .rsp_span_color (rsp_span_color),
      .rsp_span_scale (rsp_span_scale),
      .rsp_last       (rsp_last)
   );

endmodule

>>> hdl/sgsg_checker.sv
// Port-level checks of the scaled glyph span generator and their binding.
module sgsg_checker
   import sgsg_pkg::*;
#(
   parameter int MAX_SCALE = MAX_SCALE_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [LINE_BITS-1:0]  rsp_line_addr,
   input logic [ROW_BITS-1:0]   rsp_pixel_bits,
   input logic [COLOR_BITS-1:0] rsp_span_color,
   input logic [SCALE_BITS-1:0] rsp_span_scale,
   input logic                  rsp_last
);

   // No span may be offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled span holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_addr)
         && $stable(rsp_pixel_bits) && $stable(rsp_span_color) && $stable(rsp_last))
      else $error("stalled span changed");

   // Taking a span that is not the last brings the next span of the same glyph
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid
         && $stable(rsp_span_scale) && $stable(rsp_span_color))
      else $error("glyph spans not contiguous");

   // Scale shown is always the saturated one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_span_scale != '0 && rsp_span_scale <= SCALE_BITS'(MAX_SCALE))
      else $error("span scale out of range");

endmodule

bind scaled_glyph_span_generator sgsg_checker #(
   .MAX_SCALE (MAX_SCALE)
) u_sgsg_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_line_addr  (rsp_line_addr),
   .rsp_pixel_bits (rsp_pixel_bits),
   .rsp_span_color (rsp_span_color),
   .rsp_span_scale (rsp_span_scale),
   .rsp_last       (rsp_last)
);

>>> tb/sv/scaled_glyph_span_generator_tb.sv
// Self-checking testbench of the scaled glyph span generator: font loads, scaled draws, spans.
module scaled_glyph_span_generator_tb;
   import sgsg_pkg::*;

   // Run shape
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 11;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // Once every span is out only queued loads remain, and each is written from the back
   // part's idle state, so this is ample time for the block to fall quiet.
   localparam int SETTLE_CYCLES = 12;
   // Long receiver hold-off, well beyond what the two-entry queue can absorb
   localparam int HOLD_CYCLES   = 600;
   localparam int PHASE_ITEMS   = 56;
   localparam int NUM_PHASES    = 8;
   localparam int NUM_ROWS      = 22;
   localparam int REPORT_LIMIT  = 100;
   localparam int FONT_WORDS    = 2 * FONT_CODES_DEF;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One request transaction, field by field
   typedef struct packed {
      logic                  action;
      logic [CODE_BITS-1:0]  code;
      logic                  half;
      logic [WORD_BITS-1:0]  word;
      logic [POS_BITS-1:0]   pos_x;
      logic [POS_BITS-1:0]   pos_y;
      logic [COLOR_BITS-1:0] color;
      logic [SCALE_BITS-1:0] scale;
   } glyph_item_type;

   // One response transaction
   typedef struct packed {
      logic [LINE_BITS-1:0]  line_addr;
      logic [ROW_BITS-1:0]   pixel_bits;
      logic [COLOR_BITS-1:0] color;
      logic [SCALE_BITS-1:0] scale;
      logic                  last;
   } span_type;

   // Directed row: a transaction and, where it is obvious, its first span
   typedef struct packed {
      glyph_item_type item;
      logic           typed;
      span_type       first;
   } dir_row_type;

   typedef struct packed {
      logic [STRIDE_BITS-1:0] stride;
      logic [CODE_BITS-1:0]   max_code;
      idle_mode_type          mode;
      logic                   pressure;
   } phase_type;

   localparam span_type NO_SPAN = '0;

   // Directed table, walked in order straight after reset (stride 1024, max code 127).
   // Typed first spans override the predicted first span of their draw.
   dir_row_type dir_rows [NUM_ROWS] = '{
      // code above max_code straight after reset: black cell
      '{'{ACT_DRAW, 8'd200, 1'b0, 64'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 3'd1}, 1'b1,
        '{24'h000000, 8'h00, 32'h0000_0000, 3'd1, 1'b0}},
      '{'{ACT_LOAD, 8'd0, 1'b0, 64'h8040_2010_0804_0201, 12'd0, 12'd0, 32'd0, 3'd0},
        1'b0, NO_SPAN},
      '{'{ACT_LOAD, 8'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 12'd0, 32'd0, 3'd0},
        1'b0, NO_SPAN},
      '{'{ACT_DRAW, 8'd0, 1'b0, 64'd0, 12'd0, 12'd0, 32'h1234_5678, 3'd1}, 1'b1,
        '{24'h000000, 8'h01, 32'h1234_5678, 3'd1, 1'b0}},
      '{'{ACT_LOAD, 8'd127, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 12'd0, 32'd0, 3'd0},
        1'b0, NO_SPAN},
      '{'{ACT_LOAD, 8'd127, 1'b1, 64'h0, 12'd0, 12'd0, 32'd0, 3'd0}, 1'b0, NO_SPAN},
      // highest drawable code at the far corner, largest scale
      '{'{ACT_DRAW, 8'd127, 1'b0, 64'd0, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 3'd4}, 1'b1,
        '{24'h400BFF, 8'hFF, 32'hFFFF_FFFF, 3'd4, 1'b0}},
      // one above max_code: black cell
      '{'{ACT_DRAW, 8'd128, 1'b0, 64'd0, 12'd5, 12'd1, 32'hDEAD_BEEF, 3'd2}, 1'b1,
        '{24'h000405, 8'h00, 32'h0000_0000, 3'd2, 1'b0}},
      // scale of zero runs as one
      '{'{ACT_DRAW, 8'd0, 1'b0, 64'd0, 12'd0, 12'd0, 32'hA5A5_A5A5, 3'd0}, 1'b1,
        '{24'h000000, 8'h01, 32'hA5A5_A5A5, 3'd1, 1'b0}},
      // scales above the maximum saturate
      '{'{ACT_DRAW, 8'd0, 1'b0, 64'd0, 12'd100, 12'd2, 32'h0000_0001, 3'd7}, 1'b1,
        '{24'h000864, 8'h01, 32'h0000_0001, 3'd4, 1'b0}},
      '{'{ACT_DRAW, 8'd127, 1'b0, 64'd0, 12'd0, 12'd0, 32'h0000_0000, 3'd5}, 1'b1,
        '{24'h000000, 8'hFF, 32'h0000_0000, 3'd4, 1'b0}},
      '{'{ACT_LOAD, 8'd255, 1'b0, 64'h0123_4567_89AB_CDEF, 12'd0, 12'd0, 32'd0, 3'd0},
        1'b0, NO_SPAN},
      '{'{ACT_LOAD, 8'd255, 1'b1, 64'hFEDC_BA98_7654_3210, 12'd0, 12'd0, 32'd0, 3'd0},
        1'b0, NO_SPAN},
      // loaded but still above max_code: black all the same
      '{'{ACT_DRAW, 8'd255, 1'b0, 64'd0, 12'd4095, 12'd0, 32'hFFFF_FFFF, 3'd3}, 1'b1,
        '{24'h000FFF, 8'h00, 32'h0000_0000, 3'd3, 1'b0}},
      '{'{ACT_LOAD, 8'd1, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 12'd0, 12'd0, 32'd0, 3'd0},
        1'b0, NO_SPAN},
      '{'{ACT_LOAD, 8'd1, 1'b1, 64'h5555_5555_5555_5555, 12'd0, 12'd0, 32'd0, 3'd0},
        1'b0, NO_SPAN},
      '{'{ACT_DRAW, 8'd1, 1'b0, 64'd0, 12'd17, 12'd33, 32'h8000_0001, 3'd2}, 1'b0, NO_SPAN},
      '{'{ACT_DRAW, 8'd0, 1'b0, 64'd0, 12'd4000, 12'd4000, 32'h00FF_00FF, 3'd3}, 1'b0,
        NO_SPAN},
      '{'{ACT_LOAD, 8'd2, 1'b0, 64'h0, 12'd0, 12'd0, 32'd0, 3'd0}, 1'b0, NO_SPAN},
      '{'{ACT_LOAD, 8'd2, 1'b1, 64'h0, 12'd0, 12'd0, 32'd0, 3'd0}, 1'b0, NO_SPAN},
      '{'{ACT_DRAW, 8'd2, 1'b0, 64'd0, 12'd9, 12'd9, 32'h7777_7777, 3'd1}, 1'b0, NO_SPAN},
      '{'{ACT_DRAW, 8'd127, 1'b0, 64'd0, 12'd0, 12'd4095, 32'h0F0F_0F0F, 3'd6}, 1'b0,
        NO_SPAN}
   };

   // Random phases: register settings, idling pattern, and where the long hold-off falls.
   // Strides of 0 and 8191 are taken as written; 8191 with high positions wraps the offset.
   phase_type phases [NUM_PHASES] = '{
      '{13'd4096, 8'd255, IDLE_NONE,     1'b1},
      '{13'd1,    8'd0,   IDLE_SENDER,   1'b0},
      '{13'd8191, 8'd200, IDLE_RECEIVER, 1'b0},
      '{13'd0,    8'd127, IDLE_BOTH,     1'b0},
      '{13'd333,  8'd90,  IDLE_NONE,     1'b0},
      '{13'd640,  8'd255, IDLE_SENDER,   1'b0},
      '{13'd4096, 8'd63,  IDLE_RECEIVER, 1'b0},
      '{13'd2047, 8'd254, IDLE_BOTH,     1'b0}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_action;
   logic [CODE_BITS-1:0]   req_char_code;
   logic                   req_word_half;
   logic [WORD_BITS-1:0]   req_font_word;
   logic [POS_BITS-1:0]    req_pos_x;
   logic [POS_BITS-1:0]    req_pos_y;
   logic [COLOR_BITS-1:0]  req_fg_color;
   logic [SCALE_BITS-1:0]  req_scale;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [LINE_BITS-1:0]   rsp_line_addr;
   logic [ROW_BITS-1:0]    rsp_pixel_bits;
   logic [COLOR_BITS-1:0]  rsp_span_color;
   logic [SCALE_BITS-1:0]  rsp_span_scale;
   logic                   rsp_last;
   logic                   csr_write;
   logic                   csr_index;
   logic [STRIDE_BITS-1:0] csr_wdata;

   // Mirror of the block: font words, which of them were loaded, and both registers
   logic [WORD_BITS-1:0]   font_copy [FONT_WORDS];
   logic                   font_loaded [FONT_WORDS];
   logic [STRIDE_BITS-1:0] stride_q   = SCREEN_WIDTH_RST;
   logic [CODE_BITS-1:0]   max_code_q = MAX_CODE_RST;
   span_type               pending_spans [$];

   idle_mode_type          idle_mode      = IDLE_NONE;
   logic                   hold_request   = 1'b0;
   logic                   hold_taken     = 1'b0;
   int                     hold_left      = 0;
   int                     mismatch_count = 0;
   int                     span_count     = 0;
   int                     cycle_count    = 0;

   always #HALF_PERIOD clock = ~clock;

   scaled_glyph_span_generator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_word_half  (req_word_half),
      .req_font_word  (req_font_word),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_fg_color   (req_fg_color),
      .req_scale      (req_scale),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_addr  (rsp_line_addr),
      .rsp_pixel_bits (rsp_pixel_bits),
      .rsp_span_color (rsp_span_color),
      .rsp_span_scale (rsp_span_scale),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Decide whether one side idles this cycle, by the phase's idling pattern
   function automatic logic idle_roll(input logic receiver_side);
      int unsigned pct;
      case (idle_mode)
         IDLE_SENDER:   pct = receiver_side ? 0 : 67;
         IDLE_RECEIVER: pct = receiver_side ? 67 : 0;
         IDLE_BOTH:     pct = 12;
         default:       pct = 0;
      endcase
      return $urandom_range(0, 99) < pct;
   endfunction

   // Mirror one accepted transaction: a load updates the font copy, a draw queues its
   // spans top to bottom. Returns the number of spans queued.
   function automatic int predict_spans(input glyph_item_type it);
      int unsigned          sc;
      int unsigned          row;
      logic                 black;
      logic [63:0]          offset;
      logic [WORD_BITS-1:0] word;
      span_type             sp;
      if (it.action == ACT_LOAD) begin
         font_copy[{it.code, it.half}]   = it.word;
         font_loaded[{it.code, it.half}] = 1'b1;
         return 0;
      end
      // zero runs as one, anything past the maximum saturates
      if (it.scale == 0)
         sc = 1;
      else if (it.scale > MAX_SCALE_DEF)
         sc = MAX_SCALE_DEF;
      else
         sc = it.scale;
      black = it.code > max_code_q;
      for (int l = 0; l < GLYPH_ROWS * sc; l++) begin
         row    = l / sc;
         word   = black ? '0 : font_copy[{it.code, row[3]}];
         // full-width product, then wrap at the address width
         offset = 64'(it.pos_x) + (64'(it.pos_y) + 64'(l)) * 64'(stride_q);
         offset = offset & ((64'd1 << ADDR_BITS_DEF) - 64'd1);
         sp.line_addr  = offset[LINE_BITS-1:0];
         sp.pixel_bits = word[(row % 8) * ROW_BITS +: ROW_BITS];
         sp.color      = black ? '0 : it.color;
         sp.scale      = SCALE_BITS'(sc);
         sp.last       = (l == GLYPH_ROWS * sc - 1);
         pending_spans.push_back(sp);
      end
      return GLYPH_ROWS * sc;
   endfunction

   function automatic glyph_item_type random_fields();
      glyph_item_type it;
      it.action = ACT_LOAD;
      it.code   = CODE_BITS'($urandom);
      it.half   = 1'($urandom);
      it.word   = {$urandom, $urandom};
      it.pos_x  = POS_BITS'($urandom);
      it.pos_y  = POS_BITS'($urandom);
      it.color  = $urandom;
      it.scale  = SCALE_BITS'($urandom);
      return it;
   endfunction

   function automatic glyph_item_type load_item(input logic [CODE_BITS-1:0] code,
                                                input logic half);
      glyph_item_type it;
      it        = random_fields();
      it.action = ACT_LOAD;
      it.code   = code;
      it.half   = half;
      return it;
   endfunction

   // Mostly legal scales; now and then zero or a scale above the maximum
   function automatic glyph_item_type draw_item(input logic [CODE_BITS-1:0] code);
      glyph_item_type it;
      it        = random_fields();
      it.action = ACT_DRAW;
      it.code   = code;
      case ($urandom_range(0, 15))
         0:       it.scale = 3'd0;
         1:       it.scale = 3'd5;
         2:       it.scale = 3'd6;
         3:       it.scale = 3'd7;
         default: it.scale = SCALE_BITS'($urandom_range(1, MAX_SCALE_DEF));
      endcase
      // push the offset to its edges often enough to wrap with wide strides
      if ($urandom_range(0, 3) == 0)
         it.pos_x = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 3) == 0)
         it.pos_y = $urandom_range(0, 1) ? '1 : '0;
      return it;
   endfunction

   // A draw code that is either black or fully loaded; code 0 always is.
   function automatic logic [CODE_BITS-1:0] pick_draw_code();
      logic [CODE_BITS-1:0] c;
      if (max_code_q != '1 && $urandom_range(0, 3) == 0)
         return CODE_BITS'($urandom_range(int'(max_code_q) + 1, 255));
      for (int t = 0; t < 16; t++) begin
         c = CODE_BITS'($urandom_range(0, max_code_q));
         if (font_loaded[{c, 1'b0}] && font_loaded[{c, 1'b1}])
            return c;
      end
      return '0;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LIMIT)
         $display("span %0d: %s", span_count, what);
      mismatch_count++;
   endtask

   // Offer one transaction, hold it until taken, then predict what it causes.
   // Valid is left high; the next caller either offers again or drops it.
   task automatic send_item(input glyph_item_type it, output int spans);
      while (idle_roll(1'b0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= it.action;
      req_char_code <= it.code;
      req_word_half <= it.half;
      req_font_word <= it.word;
      req_pos_x     <= it.pos_x;
      req_pos_y     <= it.pos_y;
      req_fg_color  <= it.color;
      req_scale     <= it.scale;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      spans = predict_spans(it);
   endtask

   // Write one register once every span is out and any trailing load has drained
   task automatic write_csr(input logic reg_index, input logic [STRIDE_BITS-1:0] data);
      req_valid <= 1'b0;
      while (pending_spans.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (reg_index == CSR_SCREEN_WIDTH)
         stride_q = data;
      else
         max_code_q = data[CODE_BITS-1:0];
   endtask

   // Receiver: stall at random by phase, and once hold off for a long stretch so the
   // queue fills and the block has to stall its request side.
   always @(posedge clock) begin : rsp_stall_driver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_stall <= idle_roll(1'b1);
      end
   end

   // Compare every accepted span with the oldest expected one, field by field
   always @(posedge clock) begin : span_monitor
      span_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_spans.size() == 0) begin
            report_mismatch($sformatf("unexpected span, line_addr %h", rsp_line_addr));
         end else begin
            want = pending_spans.pop_front();
            if (rsp_line_addr !== want.line_addr)
               report_mismatch($sformatf("line_addr %h, want %h",
                                         rsp_line_addr, want.line_addr));
            if (rsp_pixel_bits !== want.pixel_bits)
               report_mismatch($sformatf("pixel_bits %h, want %h",
                                         rsp_pixel_bits, want.pixel_bits));
            if (rsp_span_color !== want.color)
               report_mismatch($sformatf("span_color %h, want %h",
                                         rsp_span_color, want.color));
            if (rsp_span_scale !== want.scale)
               report_mismatch($sformatf("span_scale %0d, want %0d",
                                         rsp_span_scale, want.scale));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
         span_count++;
      end
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                   spans;
      int                   idx;
      int                   n;
      logic [CODE_BITS-1:0] c;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_LOAD;
      req_char_code = '0;
      req_word_half = 1'b0;
      req_font_word = '0;
      req_pos_x     = '0;
      req_pos_y     = '0;
      req_fg_color  = '0;
      req_scale     = '0;
      csr_write     = 1'b0;
      csr_index     = CSR_SCREEN_WIDTH;
      csr_wdata     = '0;
      for (int i = 0; i < FONT_WORDS; i++)
         font_loaded[i] = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table at reset settings, no idling on either side
      foreach (dir_rows[r]) begin
         send_item(dir_rows[r].item, spans);
         if (dir_rows[r].typed) begin
            // the spans were just queued; patch the first with the typed values
            idx = pending_spans.size() - spans;
            pending_spans[idx].line_addr  = dir_rows[r].first.line_addr;
            pending_spans[idx].pixel_bits = dir_rows[r].first.pixel_bits;
            pending_spans[idx].color      = dir_rows[r].first.color;
            pending_spans[idx].scale      = dir_rows[r].first.scale;
         end
      end

      // Random phases, each under its own register setting and idling pattern
      foreach (phases[p]) begin
         write_csr(CSR_SCREEN_WIDTH, phases[p].stride);
         // junk in the bits above max_code must be dropped by the register
         write_csr(CSR_MAX_CODE, {5'($urandom), phases[p].max_code});
         idle_mode = phases[p].mode;
         if (phases[p].pressure)
            hold_request = 1'b1;
         n = 0;
         while (n < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
               // well-formed sequence: load both halves of a drawable code, draw it
               c = CODE_BITS'($urandom_range(0, max_code_q));
               send_item(load_item(c, 1'b0), spans);
               send_item(load_item(c, 1'b1), spans);
               send_item(draw_item(c), spans);
               n += 3;
            end else if ($urandom_range(0, 9) < 3) begin
               // loose load, often half a glyph only
               send_item(load_item(CODE_BITS'($urandom), 1'($urandom)), spans);
               n++;
            end else begin
               send_item(draw_item(pick_draw_code()), spans);
               n++;
            end
         end
      end

      // Drain: every expected span in, then a quiet stretch for strays
      req_valid <= 1'b0;
      while (pending_spans.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
